// ----- sv/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check of an implication over time; prop carries its own |-> or |=>.
`define ASSERT_PROP(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

// ----- sv/swudc_pkg.sv -----
package swudc_pkg;

  localparam int DEF_REPLY_BUFFER_BYTES = 32;
  localparam int WINDOW_BYTES           = 7;
  localparam int FRAME_BYTES            = 8;

  localparam logic [7:0] SYNC_BYTE  = 8'h05;
  localparam logic [7:0] WRITE_FLAG = 8'h80;
  localparam logic [7:0] REG_MASK   = 8'h7F;
  localparam logic [7:0] CRC_POLY   = 8'h07;

  localparam logic KIND_TX     = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  typedef enum logic [1:0] {
    CMD_READ       = 2'd0,
    CMD_WRITE      = 2'd1,
    CMD_RX_BYTE    = 2'd2,
    CMD_END_WINDOW = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_TIMEOUT = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  // Frame load request to the serializer: data bytes, lowest byte sent first.
  typedef struct packed {
    logic        load;
    logic [55:0] frame;
    logic [3:0]  len;
  } tx_load_t;

  // Byte offered by the serializer.
  typedef struct packed {
    logic       vld;
    logic [7:0] data;
    logic       last;
  } tx_stream_t;

  // One byte of CRC-8, polynomial 0x07, data bits fed least significant first.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int k = 0; k < 8; k++) begin
      fb = c[7] ^ data[k];
      c  = {c[6:0], 1'b0};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

endpackage

// ----- sv/swudc_cell.sv -----
module swudc_cell
  import swudc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       clr,
  input  logic       shift,
  input  logic [7:0] win_in,
  input  logic [7:0] ctb_in,
  input  logic [7:0] msg_in,
  output logic [7:0] win_q,
  output logic [7:0] ctb_q
);

  logic [7:0] win_r;
  logic [7:0] ctb_r;

  // ctb_r is this byte's share of the window CRC at its current position.
  // The CRC is linear with a zero start, so the window CRC is the XOR of all shares.
  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      win_r <= '0;
      ctb_r <= '0;
    end else if (shift) begin
      win_r <= win_in;
      ctb_r <= crc8_byte(ctb_in, msg_in);
    end
  end

  assign win_q = win_r;
  assign ctb_q = ctb_r;

endmodule

// ----- sv/swudc_tx.sv -----
module swudc_tx
  import swudc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  tx_load_t   ld,
  input  logic       adv,
  output tx_stream_t tx_o
);

  logic [55:0] frame_r, frame_nxt;
  logic [3:0]  rem_r, rem_nxt;
  logic [7:0]  crc_r, crc_nxt;

  assign tx_o.vld  = (rem_r != 4'd0);
  assign tx_o.last = (rem_r == 4'd1);
  assign tx_o.data = (rem_r == 4'd1) ? crc_r : frame_r[7:0];

  always_comb begin
    frame_nxt = frame_r;
    rem_nxt   = rem_r;
    crc_nxt   = crc_r;
    if (ld.load) begin
      frame_nxt = ld.frame;
      rem_nxt   = ld.len + 4'd1;
      crc_nxt   = '0;
    end else if (adv && tx_o.vld) begin
      frame_nxt = {8'h00, frame_r[55:8]};
      rem_nxt   = rem_r - 4'd1;
      if (!tx_o.last) begin
        crc_nxt = crc8_byte(crc_r, frame_r[7:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
    end else begin
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    frame_r <= frame_nxt;
    crc_r   <= crc_nxt;
  end

endmodule

// ----- sv/single_wire_uart_datagram_codec.sv -----
// The first frame byte of an accepted request passes through the serializer and then the
// output register; the report of a request that completes a reply or ends the window
// passes through the report register and then the output register. A read request sends
// 4 frame bytes and a write 8, one frame byte per cycle while the output does not stall.
// Reset (synchronous, rst_n low) clears the receiver, the window cells and all valid flags.
module single_wire_uart_datagram_codec
  import swudc_pkg::*;
#(
  parameter int REPLY_BUFFER_BYTES = DEF_REPLY_BUFFER_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data,   // node_address
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // register_address[6:0], write_data[38:7], rx_byte[46:39]
  input  logic [1:0]  in_tuser,   // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // tx_byte[7:0], read_value[39:8], status[41:40]
  output logic        out_tuser,  // kind
  output logic        out_tlast
);

  `include "assert_macros.svh"

  localparam int CNT_W = $clog2(REPLY_BUFFER_BYTES + 1);

  logic [1:0] node_r;

  cmd_t        cmd;
  logic [6:0]  in_reg;
  logic [31:0] in_wd;
  logic [7:0]  in_rx;
  logic        acc;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [6:0]       pend_r, pend_nxt;
  logic             found_r, found_nxt;
  logic             recv_r, recv_nxt;

  logic             rpt_vld_r, rpt_vld_nxt;
  logic [31:0]      rpt_val_r, rpt_val_nxt;
  status_t          rpt_st_r, rpt_st_nxt;

  logic             out_tvalid_r, out_tvalid_nxt;
  logic [47:0]      out_tdata_r, out_tdata_nxt;
  logic             out_tuser_r, out_tuser_nxt;
  logic             out_tlast_r, out_tlast_nxt;

  tx_load_t   tx_ld;
  tx_stream_t tx_o;
  logic       out_load_ok;
  logic       tx_adv;

  logic [7:0] cell_win_in [WINDOW_BYTES];
  logic [7:0] cell_ctb_in [WINDOW_BYTES];
  logic [7:0] cell_msg_in [WINDOW_BYTES];
  logic [7:0] cell_win    [WINDOW_BYTES];
  logic [7:0] cell_ctb    [WINDOW_BYTES];
  logic       cell_clr;
  logic       take;
  logic       match;
  logic [7:0] win_crc;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      node_r <= cfg_data;
    end
  end

  assign cmd    = cmd_t'(in_tuser);
  assign in_reg = in_tdata[6:0];
  assign in_wd  = in_tdata[38:7];
  assign in_rx  = in_tdata[46:39];

  // A new request may enter while the last frame byte or the report moves out.
  assign out_load_ok = !out_tvalid_r || out_tready;
  assign in_tready   = (!tx_o.vld || (tx_o.last && out_load_ok)) &&
                       (!rpt_vld_r || out_load_ok);
  assign acc         = in_tvalid && in_tready;
  assign tx_adv      = out_load_ok && !rpt_vld_r;

  always_comb begin
    tx_ld.load  = acc && (cmd == CMD_READ || cmd == CMD_WRITE);
    tx_ld.frame = {32'h0, 1'b0, in_reg, 6'h00, node_r, SYNC_BYTE};
    tx_ld.len   = 4'd3;
    if (cmd == CMD_WRITE) begin
      tx_ld.frame = {in_wd[7:0], in_wd[15:8], in_wd[23:16], in_wd[31:24],
                     {1'b0, in_reg} | WRITE_FLAG, 6'h00, node_r, SYNC_BYTE};
      tx_ld.len   = 4'd7;
    end
  end

  swudc_tx u_tx (
    .clk   (clk),
    .rst_n (rst_n),
    .ld    (tx_ld),
    .adv   (tx_adv),
    .tx_o  (tx_o)
  );

  // Reply window: cell 0 holds the oldest byte; bytes move toward it on each take.
  assign cell_clr = acc && (cmd == CMD_READ);
  assign take     = acc && (cmd == CMD_RX_BYTE) && recv_r && !found_r &&
                    (cnt_r < CNT_W'(REPLY_BUFFER_BYTES));

  always_comb begin
    for (int j = 0; j < WINDOW_BYTES; j++) begin
      if (j == WINDOW_BYTES - 1) begin
        cell_win_in[j] = in_rx;
        cell_ctb_in[j] = 8'h00;
        cell_msg_in[j] = in_rx;
      end else begin
        cell_win_in[j] = cell_win[j+1];
        cell_ctb_in[j] = cell_ctb[j+1];
        cell_msg_in[j] = 8'h00;
      end
    end
  end

  for (genvar g = 0; g < WINDOW_BYTES; g++) begin : g_cell
    swudc_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .clr    (cell_clr),
      .shift  (take),
      .win_in (cell_win_in[g]),
      .ctb_in (cell_ctb_in[g]),
      .msg_in (cell_msg_in[g]),
      .win_q  (cell_win[g]),
      .ctb_q  (cell_ctb[g])
    );
  end

  always_comb begin
    win_crc = 8'h00;
    for (int j = 0; j < WINDOW_BYTES; j++) begin
      win_crc = win_crc ^ cell_ctb[j];
    end
  end

  assign match = (cnt_r >= CNT_W'(WINDOW_BYTES)) && (cell_win[0] == SYNC_BYTE) &&
                 ((cell_win[2] & REG_MASK) == {1'b0, pend_r}) && (win_crc == in_rx);

  always_comb begin
    cnt_nxt   = cnt_r;
    pend_nxt  = pend_r;
    found_nxt = found_r;
    recv_nxt  = recv_r;
    rpt_vld_nxt = rpt_vld_r && !out_load_ok;
    rpt_val_nxt = rpt_val_r;
    rpt_st_nxt  = rpt_st_r;
    if (acc) begin
      unique case (cmd)
        CMD_READ: begin
          cnt_nxt   = '0;
          pend_nxt  = in_reg;
          found_nxt = 1'b0;
          recv_nxt  = 1'b1;
        end
        CMD_WRITE: begin
        end
        CMD_RX_BYTE: begin
          if (take) begin
            cnt_nxt = cnt_r + CNT_W'(1);
            if (match) begin
              found_nxt   = 1'b1;
              rpt_vld_nxt = 1'b1;
              rpt_val_nxt = {cell_win[3], cell_win[4], cell_win[5], cell_win[6]};
              rpt_st_nxt  = ST_OK;
            end
          end
        end
        CMD_END_WINDOW: begin
          if (recv_r) begin
            recv_nxt = 1'b0;
            if (!found_r) begin
              rpt_vld_nxt = 1'b1;
              rpt_val_nxt = '0;
              rpt_st_nxt  = (cnt_r < CNT_W'(FRAME_BYTES)) ? ST_TIMEOUT : ST_INVALID;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    out_tlast_nxt  = out_tlast_r;
    if (out_load_ok) begin
      if (rpt_vld_r) begin
        out_tvalid_nxt = 1'b1;
        out_tdata_nxt  = {6'h00, rpt_st_r, rpt_val_r, 8'h00};
        out_tuser_nxt  = KIND_REPORT;
        out_tlast_nxt  = 1'b1;
      end else if (tx_o.vld) begin
        out_tvalid_nxt = 1'b1;
        out_tdata_nxt  = {6'h00, ST_OK, 32'h0, tx_o.data};
        out_tuser_nxt  = KIND_TX;
        out_tlast_nxt  = tx_o.last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      pend_r       <= '0;
      found_r      <= 1'b0;
      recv_r       <= 1'b0;
      rpt_vld_r    <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      cnt_r        <= cnt_nxt;
      pend_r       <= pend_nxt;
      found_r      <= found_nxt;
      recv_r       <= recv_nxt;
      rpt_vld_r    <= rpt_vld_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rpt_val_r   <= rpt_val_nxt;
    rpt_st_r    <= rpt_st_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
    out_tlast_r <= out_tlast_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

  `ASSERT_ALWAYS(a_tx_rpt_excl, !(tx_o.vld && rpt_vld_r),
                 "frame serializer and report pending at once")
  `ASSERT_ALWAYS(a_cnt_cap, cnt_r <= CNT_W'(REPLY_BUFFER_BYTES),
                 "reply count beyond buffer size")
  `ASSERT_PROP(a_found_cnt, found_r |-> (cnt_r >= CNT_W'(FRAME_BYTES)),
               "match recorded with fewer than eight bytes")
  `ASSERT_PROP(a_rpt_moves, (rpt_vld_r && out_load_ok) |=>
               (out_tvalid && out_tuser == KIND_REPORT && out_tlast),
               "pending report not placed in output register")

endmodule

// ----- sim/single_wire_uart_datagram_codec_tb.sv -----
`timescale 1ns / 100ps

module single_wire_uart_datagram_codec_tb;
  import swudc_pkg::*;

  localparam int BUF_BYTES     = DEF_REPLY_BUFFER_BYTES;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASE_ITEMS   = 24;

  typedef struct packed {
    logic        kind;
    logic [7:0]  tx;
    logic        last;
    logic [31:0] value;
    logic [1:0]  status;
  } codec_word_t;

  typedef struct {
    cmd_t        cmd;
    logic [6:0]  reg_a;
    logic [31:0] wdata;
    logic [7:0]  rxb;
    int          typed;     // -1: use the predictor, 0: no result, 1: one report
    status_t     typed_st;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  // Predictor state.
  logic [7:0]  rx_window [7];
  int unsigned rx_count;
  logic [6:0]  wanted_reg;
  bit          reply_matched;
  bit          rx_armed;
  logic [1:0]  node_addr;

  codec_word_t step_words [$];
  codec_word_t expected_out [$];
  stim_row_t   directed_rows [$];
  int          applied_items;
  int          mismatches;
  int          cycle_count;
  bit          idle_on;

  single_wire_uart_datagram_codec #(
    .REPLY_BUFFER_BYTES(BUF_BYTES)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("single_wire_uart_datagram_codec_tb failed");
      $finish;
    end
  end

  // Receiver stalls.
  always @(negedge clk) begin
    out_tready = !idle_on || ($urandom_range(99) >= 18);
  end

  // CRC-8 with polynomial 0x07, data fed least significant bit first.
  function automatic logic [7:0] crc8_lsb(input logic [7:0] b [8], input int n);
    logic [7:0] crc;
    logic       fb;
    crc = 8'h00;
    for (int i = 0; i < n; i++) begin
      for (int k = 0; k < 8; k++) begin
        fb  = crc[7] ^ b[i][k];
        crc = {crc[6:0], 1'b0};
        if (fb) begin
          crc = crc ^ CRC_POLY;
        end
      end
    end
    return crc;
  endfunction

  function automatic void emit_frame(input logic [7:0] f [8], input int n);
    for (int i = 0; i < n; i++) begin
      step_words.push_back('{KIND_TX, f[i], (i == n - 1), 32'h0, ST_OK});
    end
  endfunction

  // Advances the datagram state by one request and fills step_words with the
  // results it causes. Returns 0 when the request is ignored.
  function automatic bit step_datagram(input cmd_t cmd, input logic [6:0] reg_a,
                                       input logic [31:0] wdata, input logic [7:0] rxb);
    logic [7:0] f [8];
    logic [7:0] win8 [8];
    step_words.delete();
    f = '{default: 8'h00};
    case (cmd)
      CMD_READ: begin
        f[0] = SYNC_BYTE;
        f[1] = {6'b0, node_addr};
        f[2] = {1'b0, reg_a};
        f[3] = crc8_lsb(f, 3);
        emit_frame(f, 4);
        rx_window     = '{default: 8'h00};
        rx_count      = 0;
        wanted_reg    = reg_a;
        reply_matched = 1'b0;
        rx_armed      = 1'b1;
        return 1'b1;
      end
      CMD_WRITE: begin
        f[0] = SYNC_BYTE;
        f[1] = {6'b0, node_addr};
        f[2] = {1'b0, reg_a} | WRITE_FLAG;
        f[3] = wdata[31:24];
        f[4] = wdata[23:16];
        f[5] = wdata[15:8];
        f[6] = wdata[7:0];
        f[7] = crc8_lsb(f, 7);
        emit_frame(f, FRAME_BYTES);
        return 1'b1;
      end
      CMD_RX_BYTE: begin
        if (!rx_armed || reply_matched || rx_count >= BUF_BYTES) begin
          return 1'b0;
        end
        rx_count++;
        for (int i = 0; i < 7; i++) begin
          win8[i] = rx_window[i];
        end
        win8[7] = 8'h00;
        if (rx_count >= FRAME_BYTES && rx_window[0] == SYNC_BYTE &&
            (rx_window[2] & REG_MASK) == {1'b0, wanted_reg} &&
            crc8_lsb(win8, 7) == rxb) begin
          reply_matched = 1'b1;
          step_words.push_back('{KIND_REPORT, 8'h00, 1'b1,
                                 {rx_window[3], rx_window[4], rx_window[5], rx_window[6]},
                                 ST_OK});
        end
        for (int i = 0; i < 6; i++) begin
          rx_window[i] = rx_window[i + 1];
        end
        rx_window[6] = rxb;
        return 1'b1;
      end
      default: begin
        if (!rx_armed) begin
          return 1'b0;
        end
        rx_armed = 1'b0;
        if (!reply_matched) begin
          step_words.push_back('{KIND_REPORT, 8'h00, 1'b1, 32'h0,
                                 (rx_count < FRAME_BYTES) ? ST_TIMEOUT : ST_INVALID});
        end
        return 1'b1;
      end
    endcase
  endfunction

  // A reply frame for register r; flaw 1 breaks the sync byte, 2 the register,
  // 3 the CRC.
  function automatic void build_reply(input logic [6:0] r, input logic [31:0] v,
                                      input int flaw, output logic [7:0] f [8]);
    f[0] = SYNC_BYTE;
    f[1] = 8'($urandom);
    f[2] = {1'($urandom), r};
    f[3] = v[31:24];
    f[4] = v[23:16];
    f[5] = v[15:8];
    f[6] = v[7:0];
    if (flaw == 1) begin
      f[0] = f[0] ^ (8'h01 << $urandom_range(7));
    end else if (flaw == 2) begin
      f[2] = f[2] ^ (8'h01 << $urandom_range(6));
    end
    f[7] = crc8_lsb(f, 7);
    if (flaw == 3) begin
      f[7] = f[7] ^ (8'h01 << $urandom_range(7));
    end
  endfunction

  function automatic void add_row(input cmd_t cmd, input logic [6:0] reg_a,
                                  input logic [31:0] wdata, input logic [7:0] rxb,
                                  input int typed, input status_t st);
    directed_rows.push_back('{cmd, reg_a, wdata, rxb, typed, st});
  endfunction

  function automatic void add_reply_rows(input logic [6:0] r, input logic [31:0] v,
                                         input int flaw);
    logic [7:0] f [8];
    build_reply(r, v, flaw, f);
    for (int i = 0; i < FRAME_BYTES; i++) begin
      add_row(CMD_RX_BYTE, 7'h0, 32'h0, f[i], -1, ST_OK);
    end
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(input cmd_t cmd, input logic [6:0] reg_a,
                              input logic [31:0] wdata, input logic [7:0] rxb,
                              input int typed, input status_t st);
    bit took;
    while (idle_on && $urandom_range(99) < 18) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = cmd;
    in_tdata  = {1'b0, rxb, wdata, reg_a};
    do begin
      @(posedge clk);
    end while (!in_tready);
    took = step_datagram(cmd, reg_a, wdata, rxb);
    if (took) begin
      applied_items++;
    end
    if (typed < 0) begin
      foreach (step_words[i]) begin
        expected_out.push_back(step_words[i]);
      end
    end else if (typed == 1) begin
      expected_out.push_back('{KIND_REPORT, 8'h00, 1'b1, 32'h0, st});
    end
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic write_node_addr(input logic [1:0] v);
    cfg_valid = 1'b1;
    cfg_data  = v;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    node_addr = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Waits until every expected result has come, then waits on for work that causes no
  // result.
  task automatic settle();
    while (expected_out.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic run_random_phase(input int goal);
    int         nb;
    int         flaw;
    int         pick;
    logic [6:0] r;
    logic [7:0] f [8];
    while (applied_items < goal) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        send_request(cmd_t'($urandom_range(3)), 7'($urandom), $urandom, 8'($urandom),
                     -1, ST_OK);
      end else if (pick < 20) begin
        send_request(CMD_WRITE, 7'($urandom), $urandom, 8'($urandom), -1, ST_OK);
      end else begin
        r = 7'($urandom);
        send_request(CMD_READ, r, $urandom, 8'($urandom), -1, ST_OK);
        if ($urandom_range(4) == 0) begin
          send_request(CMD_WRITE, 7'($urandom), $urandom, 8'($urandom), -1, ST_OK);
        end
        // Now and then a long run of noise fills the reply buffer.
        nb = ($urandom_range(7) == 0) ? 30 : $urandom_range(3);
        repeat (nb) send_request(CMD_RX_BYTE, 7'($urandom), $urandom, 8'($urandom),
                                 -1, ST_OK);
        flaw = ($urandom_range(9) < 7) ? 0 : $urandom_range(1, 3);
        build_reply(r, $urandom, flaw, f);
        nb = ($urandom_range(5) == 0) ? $urandom_range(1, 7) : FRAME_BYTES;
        for (int i = 0; i < nb; i++) begin
          send_request(CMD_RX_BYTE, 7'($urandom), $urandom, f[i], -1, ST_OK);
        end
        if ($urandom_range(3) == 0) begin
          repeat ($urandom_range(1, 3))
            send_request(CMD_RX_BYTE, 7'($urandom), $urandom, 8'($urandom), -1, ST_OK);
        end
        // Leaving out the window end makes the next read rearm an armed receiver.
        if ($urandom_range(9) != 0) begin
          send_request(CMD_END_WINDOW, 7'($urandom), $urandom, 8'($urandom), -1, ST_OK);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    codec_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_out.size() == 0) begin
        $error("unexpected result: kind %0d tdata %h last %0d", out_tuser, out_tdata,
               out_tlast);
        mismatches++;
      end else begin
        want = expected_out.pop_front();
        if (out_tuser !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_tuser);
          mismatches++;
        end
        if (out_tdata[7:0] !== want.tx) begin
          $error("tx_byte: expected %h, got %h", want.tx, out_tdata[7:0]);
          mismatches++;
        end
        if (out_tlast !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_tlast);
          mismatches++;
        end
        if (out_tdata[39:8] !== want.value) begin
          $error("read_value: expected %h, got %h", want.value, out_tdata[39:8]);
          mismatches++;
        end
        if (out_tdata[41:40] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_tdata[41:40]);
          mismatches++;
        end
      end
    end
  end

  initial begin
    logic [1:0] node_settings [4];
    node_settings = '{2'd3, 2'd0, 2'd1, 2'd2};
    rst_n         = 1'b0;
    cfg_valid     = 1'b0;
    cfg_data      = 2'd0;
    in_tvalid     = 1'b0;
    in_tdata      = 48'h0;
    in_tuser      = CMD_READ;
    out_tready    = 1'b0;
    cycle_count   = 0;
    mismatches    = 0;
    applied_items = 0;
    idle_on       = 1'b1;
    rx_window     = '{default: 8'h00};
    rx_count      = 0;
    wanted_reg    = 7'h0;
    reply_matched = 1'b0;
    rx_armed      = 1'b0;
    node_addr     = 2'd0;

    // Directed part, run with the node address left at its reset value.
    add_row(CMD_END_WINDOW, 7'h00, 32'h0, 8'h00, 0, ST_OK);
    add_row(CMD_RX_BYTE, 7'h00, 32'h0, 8'hFF, 0, ST_OK);
    add_row(CMD_READ, 7'h00, 32'h0, 8'h00, -1, ST_OK);
    add_row(CMD_WRITE, 7'h7F, 32'hFFFF_FFFF, 8'h00, -1, ST_OK);
    add_row(CMD_WRITE, 7'h00, 32'h0000_0000, 8'h00, -1, ST_OK);
    add_row(CMD_RX_BYTE, 7'h00, 32'h0, 8'h00, 0, ST_OK);
    add_row(CMD_END_WINDOW, 7'h00, 32'h0, 8'h00, 1, ST_TIMEOUT);
    add_row(CMD_END_WINDOW, 7'h00, 32'h0, 8'h00, 0, ST_OK);
    add_row(CMD_READ, 7'h7F, 32'h0, 8'h00, -1, ST_OK);
    add_reply_rows(7'h7F, 32'hFFFF_FFFF, 0);
    // Bytes after a match are dropped, and the window end then stays silent.
    add_row(CMD_RX_BYTE, 7'h00, 32'h0, 8'h00, 0, ST_OK);
    add_row(CMD_END_WINDOW, 7'h00, 32'h0, 8'h00, 0, ST_OK);
    add_row(CMD_READ, 7'h55, 32'h0, 8'h00, -1, ST_OK);
    add_reply_rows(7'h55, 32'h1234_5678, 2);
    add_row(CMD_END_WINDOW, 7'h00, 32'h0, 8'h00, 1, ST_INVALID);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].cmd, directed_rows[i].reg_a, directed_rows[i].wdata,
                   directed_rows[i].rxb, directed_rows[i].typed, directed_rows[i].typed_st);
    end

    for (int p = 0; p < 4; p++) begin
      settle();
      write_node_addr(node_settings[p]);
      idle_on = (p != 2);
      run_random_phase(applied_items + PHASE_ITEMS);
    end
    idle_on = 1'b1;
    settle();

    if (mismatches == 0 && expected_out.size() == 0) begin
      $display("single_wire_uart_datagram_codec_tb passed");
    end else begin
      $display("single_wire_uart_datagram_codec_tb failed");
    end
    $finish;
  end

endmodule
